/* rtl/gda_pkg.sv */
// Shared types, constants and the microcode program of the date adder.
// No dependencies; every other file of the block but gda_stream_if refers to this package.
`timescale 1ns / 1ps

package gda_pkg;

  // Field widths of the words and of the configuration registers
  localparam int YEAR_W    = 14;
  localparam int MONTH_W   = 4;
  localparam int DAY_W     = 5;
  localparam int WDAY_W    = 3;
  localparam int OFFSET_W  = 20;
  localparam int CFG_DATA_W = 14;
  localparam int CFG_IDX_W = 2;

  // Working year: start year up to 16383 plus about 2900 years of offset
  localparam int WYEAR_W = 15;

  // Year position inside the 400-year Gregorian cycle
  localparam int CYC_W   = 14;
  localparam logic [CYC_W-1:0] CYCLE_LEN  = 14'd400;
  localparam logic [CYC_W-1:0] CYCLE_LAST = 14'd399;
  localparam logic [CYC_W-1:0] CENT_1 = 14'd100;
  localparam logic [CYC_W-1:0] CENT_2 = 14'd200;
  localparam logic [CYC_W-1:0] CENT_3 = 14'd300;

  localparam logic [8:0] YEAR_LEN  = 9'd365;
  localparam logic [8:0] LEAP_LEN  = 9'd366;
  localparam logic [MONTH_W-1:0] JANUARY  = 4'd1;
  localparam logic [MONTH_W-1:0] DECEMBER = 4'd12;

  // Reset values of the configuration registers
  localparam logic [YEAR_W-1:0]  RST_YEAR  = 14'd2024;
  localparam logic [MONTH_W-1:0] RST_MONTH = 4'd10;
  localparam logic [DAY_W-1:0]   RST_DAY   = 5'd24;
  localparam logic [WDAY_W-1:0]  RST_WDAY  = 3'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_YEAR    = 2'd0,
    CFG_START_MONTH   = 2'd1,
    CFG_START_DAY     = 2'd2,
    CFG_START_WEEKDAY = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [OFFSET_W-1:0] day_offset;
  } in_word_t;

  typedef struct packed {
    logic [YEAR_W-1:0]  out_year;
    logic [MONTH_W-1:0] out_month;
    logic [DAY_W-1:0]   out_day;
    logic [WDAY_W-1:0]  out_weekday;
  } out_word_t;

  // Microcode
  localparam int UPC_W = 2;

  typedef enum logic [1:0] {
    OP_LOAD,   // flag: input word present
    OP_MOD,    // flag: cycle position still >= 400
    OP_WALK,   // flag: walk not finished
    OP_EMIT    // flag: output register still occupied
  } op_t;

  typedef enum logic [1:0] {
    JC_NEXT,   // fall through to the next step
    JC_FLAG,   // jump when the flag is set
    JC_NFLAG   // jump when the flag is clear
  } jc_t;

  typedef struct packed {
    op_t              op;
    jc_t              jc;
    logic [UPC_W-1:0] target;
  } ctrl_word_t;

  localparam logic [UPC_W-1:0] STEP_LOAD = 2'd0;
  localparam logic [UPC_W-1:0] STEP_MOD  = 2'd1;
  localparam logic [UPC_W-1:0] STEP_WALK = 2'd2;
  localparam logic [UPC_W-1:0] STEP_EMIT = 2'd3;

  function automatic ctrl_word_t ucode_rom(input logic [UPC_W-1:0] step);
    ctrl_word_t w;
    case (step)
      STEP_LOAD: w = '{op: OP_LOAD, jc: JC_NFLAG, target: STEP_LOAD};
      STEP_MOD:  w = '{op: OP_MOD,  jc: JC_FLAG,  target: STEP_MOD};
      STEP_WALK: w = '{op: OP_WALK, jc: JC_FLAG,  target: STEP_WALK};
      STEP_EMIT: w = '{op: OP_EMIT, jc: JC_FLAG,  target: STEP_EMIT};
      default:   w = '{op: OP_LOAD, jc: JC_NFLAG, target: STEP_LOAD};
    endcase
    return w;
  endfunction

  // Days in a month, month 1..12
  function automatic logic [DAY_W-1:0] month_len(input logic leap,
                                                 input logic [MONTH_W-1:0] month);
    logic [DAY_W-1:0] len;
    case (month)
      4'd2:                      len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

  // Residue mod 7 of a small value (below 56)
  function automatic logic [WDAY_W-1:0] mod7_small(input logic [5:0] v);
    logic [5:0] t;
    t = v;
    if (t >= 6'd28) t = t - 6'd28;
    if (t >= 6'd14) t = t - 6'd14;
    if (t >= 6'd7)  t = t - 6'd7;
    return t[WDAY_W-1:0];
  endfunction

  // Sum of two weekdays, mod 7
  function automatic logic [WDAY_W-1:0] add7(input logic [WDAY_W-1:0] a,
                                             input logic [WDAY_W-1:0] b);
    logic [WDAY_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= 4'd7) s = s - 4'd7;
    return s[WDAY_W-1:0];
  endfunction

endpackage

/* rtl/gda_stream_if.sv */
// Valid/ready stream channel carrying one payload word of type T.
// Payload types come from gda_pkg at the instantiation site.
`timescale 1ns / 1ps

interface gda_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/gda_ucode_seq.sv */
// Step counter and microcode ROM: issues one control word per cycle.
// Depends on gda_pkg for the control word layout and the program.
`timescale 1ns / 1ps

module gda_ucode_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                flag,
  output gda_pkg::ctrl_word_t ctrl
);

  logic [gda_pkg::UPC_W-1:0] upc_r;
  logic [gda_pkg::UPC_W-1:0] upc_nxt;
  logic                      take_jump;

  assign ctrl = gda_pkg::ucode_rom(upc_r);

  always_comb begin
    case (ctrl.jc)
      gda_pkg::JC_FLAG:  take_jump = flag;
      gda_pkg::JC_NFLAG: take_jump = !flag;
      default:           take_jump = 1'b0;
    endcase
    // the last step wraps back to the load step
    upc_nxt = take_jump ? ctrl.target : upc_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= gda_pkg::STEP_LOAD;
    end else begin
      upc_r <= upc_nxt;
    end
  end

endmodule

/* rtl/gda_datapath.sv */
// Datapath of the date adder: year/month walk, leap cycle, weekday, output word.
// Driven by control words from gda_ucode_seq; types from gda_pkg.
`timescale 1ns / 1ps

module gda_datapath #(
  parameter int OFFSET_BITS = 20
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  gda_pkg::ctrl_word_t                ctrl,
  output logic                               flag,
  input  logic                               in_valid,
  input  logic [gda_pkg::OFFSET_W-1:0]       day_offset,
  input  logic [gda_pkg::YEAR_W-1:0]         start_year,
  input  logic [gda_pkg::MONTH_W-1:0]        start_month,
  input  logic [gda_pkg::DAY_W-1:0]          start_day,
  input  logic [gda_pkg::WDAY_W-1:0]         start_weekday,
  output logic                               out_valid,
  input  logic                               out_ready,
  output gda_pkg::out_word_t                 out_word
);

  localparam int OFF_W = (OFFSET_BITS < gda_pkg::OFFSET_W) ? OFFSET_BITS : gda_pkg::OFFSET_W;
  localparam int REST_W = OFF_W + 1;

  logic [gda_pkg::WYEAR_W-1:0] year_r,  year_nxt;
  logic [gda_pkg::MONTH_W-1:0] month_r, month_nxt;
  logic [REST_W-1:0]           rest_r,  rest_nxt;
  logic [gda_pkg::CYC_W-1:0]   cyc_r,   cyc_nxt;
  logic [gda_pkg::WDAY_W-1:0]  wdb_r,   wdb_nxt;
  gda_pkg::out_word_t          out_r,   out_nxt;
  logic                        out_valid_r, out_valid_nxt;

  // load-time values
  logic [gda_pkg::MONTH_W-1:0] ld_month;
  logic [gda_pkg::DAY_W-1:0]   ld_dm1;
  logic [gda_pkg::WDAY_W-1:0]  ld_swd;
  logic [gda_pkg::WDAY_W-1:0]  ld_dm1_mod;
  logic [gda_pkg::WDAY_W:0]    ld_wdb;

  // walk values
  logic                        leap;
  logic [gda_pkg::DAY_W-1:0]   mlen;
  logic [8:0]                  ylen;
  logic                        year_step;
  logic                        walk_done;
  logic [gda_pkg::CYC_W-1:0]   cyc_inc;
  logic                        out_busy;

  assign out_valid = out_valid_r;
  assign out_word  = out_r;
  assign out_busy  = out_valid_r && !out_ready;

  always_comb begin
    ld_month = start_month;
    if (start_month < gda_pkg::JANUARY)  ld_month = gda_pkg::JANUARY;
    if (start_month > gda_pkg::DECEMBER) ld_month = gda_pkg::DECEMBER;
    ld_dm1 = (start_day == '0) ? '0 : start_day - 1'b1;
    ld_swd = (start_weekday == 3'd7) ? '0 : start_weekday;
    ld_dm1_mod = gda_pkg::mod7_small({1'b0, ld_dm1});
    // weekday of the 1st of the start month
    ld_wdb = {1'b0, ld_swd} + 4'd7 - {1'b0, ld_dm1_mod};
    if (ld_wdb >= 4'd7) ld_wdb = ld_wdb - 4'd7;
  end

  always_comb begin
    leap = (cyc_r[1:0] == 2'b00) && !(cyc_r == gda_pkg::CENT_1 ||
           cyc_r == gda_pkg::CENT_2 || cyc_r == gda_pkg::CENT_3);
    mlen = gda_pkg::month_len(leap, month_r);
    ylen = leap ? gda_pkg::LEAP_LEN : gda_pkg::YEAR_LEN;
    year_step = (month_r == gda_pkg::JANUARY) && (rest_r >= REST_W'(ylen));
    walk_done = !year_step && (rest_r < REST_W'(mlen));
    cyc_inc = (cyc_r == gda_pkg::CYCLE_LAST) ? '0 : cyc_r + 1'b1;
  end

  always_comb begin
    year_nxt      = year_r;
    month_nxt     = month_r;
    rest_nxt      = rest_r;
    cyc_nxt       = cyc_r;
    wdb_nxt       = wdb_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    flag          = 1'b0;
    case (ctrl.op)
      gda_pkg::OP_LOAD: begin
        flag = in_valid;
        if (in_valid) begin
          year_nxt  = {{(gda_pkg::WYEAR_W - gda_pkg::YEAR_W){1'b0}}, start_year};
          month_nxt = ld_month;
          rest_nxt  = REST_W'(day_offset[OFF_W-1:0]) + REST_W'(ld_dm1);
          cyc_nxt   = start_year;
          wdb_nxt   = ld_wdb[gda_pkg::WDAY_W-1:0];
        end
      end
      gda_pkg::OP_MOD: begin
        flag = (cyc_r >= gda_pkg::CYCLE_LEN);
        if (flag) cyc_nxt = cyc_r - gda_pkg::CYCLE_LEN;
      end
      gda_pkg::OP_WALK: begin
        flag = !walk_done;
        if (year_step) begin
          // whole year from January 1st
          rest_nxt = rest_r - REST_W'(ylen);
          year_nxt = year_r + 1'b1;
          cyc_nxt  = cyc_inc;
          wdb_nxt  = gda_pkg::add7(wdb_r, leap ? 3'd2 : 3'd1);
        end else if (!walk_done) begin
          rest_nxt = rest_r - REST_W'(mlen);
          wdb_nxt  = gda_pkg::add7(wdb_r, 3'(mlen - 5'd28));
          if (month_r == gda_pkg::DECEMBER) begin
            month_nxt = gda_pkg::JANUARY;
            year_nxt  = year_r + 1'b1;
            cyc_nxt   = cyc_inc;
          end else begin
            month_nxt = month_r + 1'b1;
          end
        end
      end
      gda_pkg::OP_EMIT: begin
        flag = out_busy;
        if (!out_busy) begin
          out_nxt.out_year    = year_r[gda_pkg::YEAR_W-1:0];
          out_nxt.out_month   = month_r;
          out_nxt.out_day     = rest_r[gda_pkg::DAY_W-1:0] + 1'b1;
          out_nxt.out_weekday = gda_pkg::mod7_small({3'b000, wdb_r} +
                                                    {1'b0, rest_r[gda_pkg::DAY_W-1:0]});
          out_valid_nxt       = 1'b1;
        end
      end
      default: flag = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    year_r  <= year_nxt;
    month_r <= month_nxt;
    rest_r  <= rest_nxt;
    cyc_r   <= cyc_nxt;
    wdb_r   <= wdb_nxt;
    out_r   <= out_nxt;
  end

endmodule

/* rtl/gregorian_date_add_days.sv */
// Top level of the Gregorian date adder: configuration registers and channels.
// Depends on gda_pkg, gda_stream_if, gda_ucode_seq and gda_datapath.
`timescale 1ns / 1ps

// Each input word carries a day offset; the block answers with one output word
// holding the Gregorian date that many days after the configured start date,
// plus its weekday (0 Monday .. 6 Sunday). Leap years follow the 4/100/400
// rule. Only the low OFFSET_BITS of the offset count. A start month of 0 acts
// as January, 13..15 as December, a start day of 0 as the 1st, and a start
// day past its month end rolls into the next months. The result year wraps
// at 14 bits. Words are handled one at a time by a four-step microprogram:
// the load step takes the word, the mod step takes 400 off the start year
// until it lies inside the 400-year leap cycle, the walk step takes off one
// whole year or month at a time (up to 11 months to reach January, the whole
// years, up to 11 more months) until the remainder falls inside a month, and
// the emit step hands the word to the output register, waiting there while
// that register still waits on the receiver. The walk loop does one subtract
// per cycle. The output register holds a finished word while the next input
// word is taken and worked on. Write the configuration only while the block
// is idle.
module gregorian_date_add_days #(
  parameter int OFFSET_BITS = 20
) (
  input  logic                               clk,
  input  logic                               rst_n,
  gda_stream_if.sink                         in_ch,
  gda_stream_if.source                       out_ch,
  input  logic                               cfg_we,
  input  logic [gda_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [gda_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  // Start date registers
  logic [gda_pkg::YEAR_W-1:0]  start_year_r;
  logic [gda_pkg::MONTH_W-1:0] start_month_r;
  logic [gda_pkg::DAY_W-1:0]   start_day_r;
  logic [gda_pkg::WDAY_W-1:0]  start_weekday_r;

  gda_pkg::ctrl_word_t ctrl;
  logic                flag;
  gda_pkg::out_word_t  out_word;
  logic                out_valid;

  // Write one register per enabled cycle; truncate the data to its width.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_year_r    <= gda_pkg::RST_YEAR;
      start_month_r   <= gda_pkg::RST_MONTH;
      start_day_r     <= gda_pkg::RST_DAY;
      start_weekday_r <= gda_pkg::RST_WDAY;
    end else if (cfg_we) begin
      case (cfg_idx)
        gda_pkg::CFG_START_YEAR:    start_year_r    <= cfg_wdata[gda_pkg::YEAR_W-1:0];
        gda_pkg::CFG_START_MONTH:   start_month_r   <= cfg_wdata[gda_pkg::MONTH_W-1:0];
        gda_pkg::CFG_START_DAY:     start_day_r     <= cfg_wdata[gda_pkg::DAY_W-1:0];
        gda_pkg::CFG_START_WEEKDAY: start_weekday_r <= cfg_wdata[gda_pkg::WDAY_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer: step counter plus microcode ROM
  gda_ucode_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .flag  (flag),
    .ctrl  (ctrl)
  );

  // Take a new word only while the program sits on its load step.
  assign in_ch.ready = (ctrl.op == gda_pkg::OP_LOAD);

  gda_datapath #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctrl          (ctrl),
    .flag          (flag),
    .in_valid      (in_ch.valid),
    .day_offset    (in_ch.data.day_offset),
    .start_year    (start_year_r),
    .start_month   (start_month_r),
    .start_day     (start_day_r),
    .start_weekday (start_weekday_r),
    .out_valid     (out_valid),
    .out_ready     (out_ch.ready),
    .out_word      (out_word)
  );

  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_word;

endmodule

/* tb/sv/gregorian_date_add_days_tb.sv */
// Self-checking testbench for gregorian_date_add_days: random and corner offsets, start dates.
// Depends on gda_pkg and gda_stream_if from the RTL; predicts every date word on its own.
`timescale 1ns / 1ps

module gregorian_date_add_days_tb;
  import gda_pkg::*;

  localparam int CLK_HALF      = 4;
  localparam int MAX_IDLE      = 12;
  localparam int LONG_HOLD     = 600;
  localparam int RAND_PHASES   = 7;
  localparam int WORDS_PER_PH  = 16;
  localparam int MAX_CYCLES    = 2_000_000;
  localparam int REPORT_LIMIT  = 10;

  // Expected-date store: keeps its own copy of the start-date registers,
  // walks the calendar for each accepted offset and queues the answer.
  class date_scoreboard;
    logic [YEAR_W-1:0]  base_year;
    logic [MONTH_W-1:0] base_month;
    logic [DAY_W-1:0]   base_day;
    logic [WDAY_W-1:0]  base_wday;
    out_word_t          due_dates[$];
    int                 errors;
    int                 offsets_seen;
    int                 dates_checked;

    function new();
      base_year  = RST_YEAR;
      base_month = RST_MONTH;
      base_day   = RST_DAY;
      base_wday  = RST_WDAY;
      errors = 0;
      offsets_seen = 0;
      dates_checked = 0;
    endfunction

    function void set_start(cfg_idx_t idx, logic [CFG_DATA_W-1:0] v);
      case (idx)
        CFG_START_YEAR:    base_year  = v[YEAR_W-1:0];
        CFG_START_MONTH:   base_month = v[MONTH_W-1:0];
        CFG_START_DAY:     base_day   = v[DAY_W-1:0];
        CFG_START_WEEKDAY: base_wday  = v[WDAY_W-1:0];
        default: ;
      endcase
    endfunction

    function bit is_leap_year(int unsigned y);
      return ((y % 100 != 0) && (y % 4 == 0)) || (y % 400 == 0);
    endfunction

    function int unsigned days_in_month(bit leap, int unsigned m);
      case (m)
        2:           return leap ? 29 : 28;
        4, 6, 9, 11: return 30;
        default:     return 31;
      endcase
    endfunction

    // Walk whole years from January 1st, whole months otherwise.
    function out_word_t date_after(logic [OFFSET_W-1:0] off);
      int unsigned y, m, rest, ylen, mlen;
      bit          leap;
      out_word_t   r;
      y = base_year;
      m = (base_month == 0) ? 1 : (base_month > 12) ? 12 : base_month;
      rest = off + ((base_day == 0) ? 1 : base_day) - 1;
      forever begin
        leap = is_leap_year(y);
        mlen = days_in_month(leap, m);
        if (m == 1) begin
          ylen = leap ? 366 : 365;
          if (rest >= ylen) begin
            rest -= ylen;
            y++;
            continue;
          end
        end
        if (rest < mlen) break;
        rest -= mlen;
        m++;
        if (m > 12) begin
          m = 1;
          y++;
        end
      end
      r.out_year    = y[YEAR_W-1:0];
      r.out_month   = m[MONTH_W-1:0];
      r.out_day     = 5'(rest + 1);
      r.out_weekday = 3'((int'(base_wday) + int'(off)) % 7);
      return r;
    endfunction

    function void note_offset(in_word_t w);
      due_dates.push_back(date_after(w.day_offset));
      offsets_seen++;
    endfunction

    function void check_date(out_word_t got);
      out_word_t exp_w;
      bit        bad;
      if (due_dates.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("[%0t] unexpected date word %0d-%0d-%0d wd %0d", $realtime,
                   got.out_year, got.out_month, got.out_day, got.out_weekday);
        return;
      end
      exp_w = due_dates.pop_front();
      dates_checked++;
      bad = (got.out_year !== exp_w.out_year) || (got.out_month !== exp_w.out_month) ||
            (got.out_day !== exp_w.out_day) || (got.out_weekday !== exp_w.out_weekday);
      if (bad) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("[%0t] date mismatch: expected %0d-%0d-%0d wd %0d, got %0d-%0d-%0d wd %0d",
                   $realtime, exp_w.out_year, exp_w.out_month, exp_w.out_day,
                   exp_w.out_weekday, got.out_year, got.out_month, got.out_day,
                   got.out_weekday);
      end
    endfunction

    function bit busy();
      return due_dates.size() != 0;
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  gda_stream_if #(.T(in_word_t))  in_ch();
  gda_stream_if #(.T(out_word_t)) out_ch();

  gregorian_date_add_days DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  date_scoreboard sb = new();

  // Idle controls of the driver and of the receiver, and run counters
  bit tx_quiet = 1'b0;
  bit rx_quiet = 1'b0;
  bit hold_out = 1'b0;
  int start_dates = 0;
  int cycle_cnt = 0;

  always #CLK_HALF clk = ~clk;

  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    out_ch.ready = 1'b0;
  end

  function automatic int idle_cycles(bit quiet);
    return quiet ? 0 : $urandom_range(0, MAX_IDLE);
  endfunction

  // Offer one offset word; return at the edge where it is taken.
  // Handshake inputs are sampled at the falling edge, where everything is stable.
  task automatic send_offset(logic [OFFSET_W-1:0] off);
    int gap;
    in_word_t w;
    gap = idle_cycles(tx_quiet);
    w.day_offset = off;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= w;
    do @(negedge clk); while (!in_ch.ready);
    @(posedge clk);
    sb.note_offset(w);
  endtask

  // Drop valid and wait until every outstanding date word has come back
  task automatic settle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.busy());
  endtask

  // Write all four start-date registers back to back; call only while idle
  task automatic load_start(logic [YEAR_W-1:0] y, logic [MONTH_W-1:0] m,
                            logic [DAY_W-1:0] d, logic [WDAY_W-1:0] wd);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_START_YEAR;
    cfg_wdata <= CFG_DATA_W'(y);
    sb.set_start(CFG_START_YEAR, CFG_DATA_W'(y));
    @(posedge clk);
    cfg_idx   <= CFG_START_MONTH;
    cfg_wdata <= CFG_DATA_W'(m);
    sb.set_start(CFG_START_MONTH, CFG_DATA_W'(m));
    @(posedge clk);
    cfg_idx   <= CFG_START_DAY;
    cfg_wdata <= CFG_DATA_W'(d);
    sb.set_start(CFG_START_DAY, CFG_DATA_W'(d));
    @(posedge clk);
    cfg_idx   <= CFG_START_WEEKDAY;
    cfg_wdata <= CFG_DATA_W'(wd);
    sb.set_start(CFG_START_WEEKDAY, CFG_DATA_W'(wd));
    @(posedge clk);
    cfg_we <= 1'b0;
    start_dates++;
  endtask

  // One corner start date: zero offset, full offset and one small random offset
  task automatic corner_start(logic [YEAR_W-1:0] y, logic [MONTH_W-1:0] m,
                              logic [DAY_W-1:0] d, logic [WDAY_W-1:0] wd);
    load_start(y, m, d, wd);
    send_offset('0);
    send_offset('1);
    send_offset(OFFSET_W'($urandom_range(0, 1000)));
    settle();
  endtask

  // Mostly short offsets that keep the walk brief; now and then the full range
  function automatic logic [OFFSET_W-1:0] random_offset();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return OFFSET_W'($urandom_range(0, 400));
      4, 5, 6:    return OFFSET_W'($urandom_range(0, 4000));
      7, 8:       return OFFSET_W'($urandom_range(0, 40000));
      default:    return OFFSET_W'($urandom());
    endcase
  endfunction

  // Bias years toward centuries and multiples of four, where the leap rule bites
  function automatic logic [YEAR_W-1:0] random_year();
    case ($urandom_range(0, 3))
      0:       return YEAR_W'($urandom_range(1, 9999));
      1:       return YEAR_W'(100 * $urandom_range(0, 99));
      2:       return YEAR_W'($urandom_range(0, 16383));
      default: return YEAR_W'(4 * $urandom_range(0, 2500));
    endcase
  endfunction

  // Receiver: random stalls per word, or one long hold when asked for.
  // The hold is counted here so that the driver keeps offering words meanwhile.
  initial begin : date_sink
    int stall;
    out_word_t got;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_out) begin
        stall = LONG_HOLD;
        hold_out = 1'b0;
      end else begin
        stall = idle_cycles(rx_quiet);
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(negedge clk); while (!out_ch.valid);
      got = out_ch.data;
      @(posedge clk);
      sb.check_date(got);
    end
  end

  // Watchdog: end the run if the cycle count runs past the limit
  initial begin : watchdog
    while (cycle_cnt < MAX_CYCLES) @(posedge clk);
    $display("timeout after %0d cycles, %0d dates still pending", cycle_cnt,
             sb.due_dates.size());
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : stimulus
    int ph;
    int n;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Reset start date (2024-10-24, Thursday): month ends, year end,
    // leap day and two large alternating-bit offsets
    send_offset(20'd0);
    send_offset(20'd1);
    send_offset(20'd7);
    send_offset(20'd8);
    send_offset(20'd68);
    send_offset(20'd69);
    send_offset(20'd1223);
    send_offset(20'd1224);
    send_offset(20'hAAAAA);
    send_offset(20'h55555);
    settle();

    // Corner start dates: year zero with month/day zero and weekday seven,
    // the largest year with month 15 (year wraps), day past the end of
    // February, leap day of a 400-year, and a century year with month 13
    corner_start(14'd0,     4'd0,  5'd0,  3'd7);
    corner_start(14'd16383, 4'd15, 5'd31, 3'd6);
    corner_start(14'd1,     4'd2,  5'd31, 3'd0);
    corner_start(14'd2000,  4'd2,  5'd29, 3'd5);
    corner_start(14'd1900,  4'd13, 5'd0,  3'd2);

    // Random start dates, with idling patterns that change per phase
    for (ph = 0; ph < RAND_PHASES; ph++) begin
      load_start(random_year(), MONTH_W'($urandom_range(0, 15)),
                 DAY_W'($urandom_range(0, 31)), WDAY_W'($urandom_range(0, 7)));
      tx_quiet = (ph % 3 != 0);
      rx_quiet = (ph % 3 == 1);
      // Hold the output long enough for the block to back up its input
      if (ph == 2) hold_out = 1'b1;
      for (n = 0; n < WORDS_PER_PH; n++) begin
        // Pause the driver mid-phase until everything has drained
        if (ph == 4 && n == WORDS_PER_PH / 2) settle();
        send_offset(random_offset());
      end
      settle();
    end

    repeat (16) @(posedge clk);
    $display("covered %0d offsets across %0d start dates, %0d dates checked",
             sb.offsets_seen, start_dates + 1, sb.dates_checked);
    $display("start registers hit zero, overrange and maximum values; %0d mismatches",
             sb.errors);
    if (sb.errors == 0 && !sb.busy()) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* gregorian_date_add_days.f */
rtl/gda_pkg.sv
rtl/gda_stream_if.sv
rtl/gda_ucode_seq.sv
rtl/gda_datapath.sv
rtl/gregorian_date_add_days.sv
tb/sv/gregorian_date_add_days_tb.sv
